### sv/grid_rectangle_first_fit_top_defines.svh
// ----------------------------------------------------------------------------
// Grid rectangle first-fit: assertion macros
// Shared check macros, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_RECTANGLE_FIRST_FIT_TOP_DEFINES_SVH
`define GRID_RECTANGLE_FIRST_FIT_TOP_DEFINES_SVH

// same-cycle implication
`define GRFF_CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GRFF_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/grff_pkg.sv
// ----------------------------------------------------------------------------
// grff_pkg
// Types, codes and defaults shared by the grid first-fit allocator.
// ----------------------------------------------------------------------------
package grff_pkg;

	localparam int MAX_ROWS_DEF      = 64;
	localparam int MAX_COLS_DEF      = 16;
	localparam int MAX_ITEM_SIZE_DEF = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam logic [1:0] OP_PLACE  = 2'd0;
	localparam logic [1:0] OP_PROBE  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] HINT_TRIES = 3'd5;

	typedef logic [7:0]        row_t;
	typedef logic [5:0]        col_t;
	typedef logic signed [9:0] pos_t;

	typedef struct packed {
		logic hit;
		logic any;
		col_t first;
	} fit_res_t;

	// hint neighbor order: self, right, down, up, left
	function automatic pos_t hint_dr(input logic [2:0] k);
		pos_t d;
		unique case (k)
			3'd2:    d = 10'sd1;
			3'd3:    d = -10'sd1;
			default: d = 10'sd0;
		endcase
		return d;
	endfunction

	function automatic pos_t hint_dc(input logic [2:0] k);
		pos_t d;
		unique case (k)
			3'd1:    d = 10'sd1;
			3'd4:    d = -10'sd1;
			default: d = 10'sd0;
		endcase
		return d;
	endfunction

endpackage

### sv/grff_if.sv
// ----------------------------------------------------------------------------
// grff_if
// Request and response channels of the grid first-fit allocator.
// ----------------------------------------------------------------------------
interface grff_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [3:0]        item_height;
	logic [3:0]        item_width;
	logic              use_hint;
	logic signed [7:0] hint_row;
	logic signed [7:0] hint_col;
	logic [5:0]        pos_row;
	logic [3:0]        pos_col;

	modport source (output valid, output op, output item_height, output item_width,
		output use_hint, output hint_row, output hint_col, output pos_row,
		output pos_col, input ready);
	modport sink (input valid, input op, input item_height, input item_width,
		input use_hint, input hint_row, input hint_col, input pos_row,
		input pos_col, output ready);
endinterface

interface grff_rsp_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [5:0] placed_row;
	logic [3:0] placed_col;
	logic [5:0] lowest_filled_row;

	modport source (output valid, output found, output placed_row, output placed_col,
		output lowest_filled_row, input ready);
	modport sink (input valid, input found, input placed_row, input placed_col,
		input lowest_filled_row, output ready);
endinterface

### sv/grff_ram.sv
// ----------------------------------------------------------------------------
// grff_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module grff_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/grff_fit.sv
// ----------------------------------------------------------------------------
// grff_fit
// Column window check on the OR of a band of rows: fit at a given column
// and first column in the band at which the window fits.
// ----------------------------------------------------------------------------
module grff_fit #(
	parameter int MAX_COLS = grff_pkg::MAX_COLS_DEF
) (
	input  logic [MAX_COLS-1:0] occ,
	input  logic [3:0]          width,
	input  logic [4:0]          ncols,
	input  grff_pkg::col_t      cand,
	output grff_pkg::fit_res_t  res
);

	import grff_pkg::*;

	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [MAX_COLS-1:0] wmask;
	logic [MAX_COLS-1:0] free;

	always_comb begin
		for (int b = 0; b < MAX_COLS; b++) begin
			wmask[b] = (b < int'(width));
		end
		for (int j = 0; j < MAX_COLS; j++) begin
			free[j] = (((occ >> j) & wmask) == '0) && (j + int'(width) <= int'(ncols));
		end
		res.any   = |free;
		res.first = '0;
		for (int j = MAX_COLS - 1; j >= 0; j--) begin
			if (free[j]) begin
				res.first = col_t'(j);
			end
		end
		res.hit = (int'(cand) < MAX_COLS) ? free[cand[CIW-1:0]] : 1'b0;
	end

endmodule

### sv/grid_rectangle_first_fit_top.sv
// ----------------------------------------------------------------------------
// grid_rectangle_first_fit_top
// Per word: accept, prepare, search (hint candidates, then band-by-band scan),
//   write-back of the rows of a placed or removed item, search for the lowest
//   filled row starting from the last grid row, then load of the response register.
// Flow: ready only while idle; a new word is taken only after the last one
//   has been loaded into the response register, and that load waits while
//   an earlier response is still held there unaccepted.
// Reset: grid empty via per-row valid flags (no clearing pass), 8 x 8 grid.
// ----------------------------------------------------------------------------
`include "grid_rectangle_first_fit_top_defines.svh"

module grid_rectangle_first_fit_top #(
	parameter int MAX_ROWS      = grff_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS      = grff_pkg::MAX_COLS_DEF,
	parameter int MAX_ITEM_SIZE = grff_pkg::MAX_ITEM_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	grff_req_if.sink                          req,
	grff_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [grff_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [grff_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import grff_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [6:0] NR_CAP  = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
	localparam logic [4:0] NC_CAP  = (MAX_COLS > 31) ? 5'd31 : 5'(MAX_COLS);
	localparam logic [3:0] ISZ_CAP = (MAX_ITEM_SIZE > 15) ? 4'd15 : 4'(MAX_ITEM_SIZE);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_HCAND = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_ACC   = 4'd4;
	localparam logic [3:0] S_EVAL  = 4'd5;
	localparam logic [3:0] S_WR    = 4'd6;
	localparam logic [3:0] S_LOWI  = 4'd7;
	localparam logic [3:0] S_LOW   = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0]          state_q;
	logic [6:0]          rows_q;
	logic [4:0]          cols_q;

	logic [1:0]          op_q;
	logic [3:0]          h_q, w_q;
	logic                hint_q;
	logic signed [7:0]   hrow_q, hcol_q;
	logic [5:0]          prow_q;
	logic [3:0]          pcol_q;

	pos_t                pr_q, pc_q;
	logic [2:0]          k_q;
	row_t                base_q;
	col_t                cand_q, wcol_q, fc_q;
	logic [3:0]          cnt_q, n_q;
	logic [MAX_COLS-1:0] or_q;
	logic                scan_q, found_q, lmore_q;
	row_t                fr_q, lrow_q, low_q;

	logic                rd_vld_q, rd_valid_q;
	row_t                rd_row_q;
	logic [MAX_ROWS-1:0] row_valid_q;

	logic                out_vld_q, out_found_q;
	logic [5:0]          out_row_q, out_low_q;
	logic [3:0]          out_col_q;

	logic [6:0]          nr;
	logic [4:0]          nc;
	logic                size_ok;
	logic [MAX_COLS-1:0] ram_q, rdata, colmask, wrmask, ram_wd;
	pos_t                pr_c, pc_c, cr, cc, nr_s, nc_s, h_s, w_s;
	logic                cand_ok, scan_fits, lhit, rd_issue, ram_we, out_load, fit_end_ok;
	row_t                rd_row;
	logic [AW-1:0]       ram_ra, ram_wa;
	logic [6:0]          avail;
	logic [3:0]          rm_n;
	fit_res_t            fit;

	assign nr      = (rows_q > NR_CAP) ? NR_CAP : rows_q;
	assign nc      = (cols_q > NC_CAP) ? NC_CAP : cols_q;
	assign size_ok = (h_q != 4'd0) && (w_q != 4'd0) && (h_q <= ISZ_CAP) && (w_q <= ISZ_CAP);
	assign rdata   = rd_valid_q ? ram_q : '0;

	assign nr_s = $signed({3'b000, nr});
	assign nc_s = $signed({5'b00000, nc});
	assign h_s  = $signed({6'b000000, h_q});
	assign w_s  = $signed({6'b000000, w_q});

	// hint clamp
	always_comb begin
		pr_c = (pos_t'(hrow_q) < 10'sd0) ? 10'sd0 : pos_t'(hrow_q);
		if (pr_c >= nr_s) begin
			pr_c = nr_s - 10'sd1 - $signed({7'b0000000, h_q[3:1]});
		end
		pc_c = (pos_t'(hcol_q) < 10'sd0) ? 10'sd0 : pos_t'(hcol_q);
		if (pc_c >= nc_s) begin
			pc_c = nc_s - 10'sd1 - $signed({7'b0000000, w_q[3:1]});
		end
	end

	assign cr      = pr_q + hint_dr(k_q);
	assign cc      = pc_q + hint_dc(k_q);
	assign cand_ok = (cr >= 10'sd0) && (cc >= 10'sd0) && (cr + h_s <= nr_s) && (cc + w_s <= nc_s);
	assign scan_fits = ({1'b0, base_q} + {5'b00000, h_q}) <= {2'b00, nr};

	always_comb begin
		avail = nr - {1'b0, prow_q};
		if ({1'b0, prow_q} >= nr) begin
			rm_n = 4'd0;
		end else if (avail < {3'b000, h_q}) begin
			rm_n = avail[3:0];
		end else begin
			rm_n = h_q;
		end
	end

	always_comb begin
		for (int b = 0; b < MAX_COLS; b++) begin
			colmask[b] = (b < int'(nc));
			wrmask[b]  = (b >= int'(wcol_q)) && (b < int'(wcol_q) + int'(w_q)) && (b < int'(nc));
		end
	end

	assign lhit = rd_vld_q && ((rdata & colmask) != '0);

	// read port control
	always_comb begin
		rd_issue = 1'b0;
		rd_row   = base_q + row_t'(cnt_q);
		unique case (state_q)
			S_ACC:   rd_issue = 1'b1;
			S_WR:    rd_issue = (cnt_q < n_q);
			S_LOW: begin
				rd_issue = lmore_q;
				rd_row   = lrow_q;
			end
			default: rd_issue = 1'b0;
		endcase
	end

	assign ram_we = (state_q == S_WR) && rd_vld_q;
	assign ram_wd = (op_q == OP_REMOVE) ? (rdata & ~wrmask) : (rdata | wrmask);
	assign ram_ra = AW'(rd_row);
	assign ram_wa = AW'(rd_row_q);

	grff_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (rd_issue),
		.raddr (ram_ra),
		.rdata (ram_q)
	);

	grff_fit #(
		.MAX_COLS (MAX_COLS)
	) u_fit (
		.occ   (or_q | rdata),
		.width (w_q),
		.ncols (nc),
		.cand  (cand_q),
		.res   (fit)
	);

	assign req.ready = (state_q == S_IDLE);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd8;
			cols_q <= 5'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data[4:0];
			endcase
		end
	end

	// request word capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.op;
			h_q    <= req.item_height;
			w_q    <= req.item_width;
			hint_q <= req.use_hint;
			hrow_q <= req.hint_row;
			hcol_q <= req.hint_col;
			prow_q <= req.pos_row;
			pcol_q <= req.pos_col;
		end
	end

	// row valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (state_q == S_PREP && op_q == OP_CLEAR) begin
			row_valid_q <= '0;
		end else if (ram_we) begin
			row_valid_q[ram_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_row_q   <= rd_row;
			rd_valid_q <= row_valid_q[ram_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			scan_q  <= 1'b0;
			found_q <= 1'b0;
			lmore_q <= 1'b0;
			pr_q    <= '0;
			pc_q    <= '0;
			base_q  <= '0;
			cand_q  <= '0;
			wcol_q  <= '0;
			fr_q    <= '0;
			fc_q    <= '0;
			or_q    <= '0;
			lrow_q  <= '0;
			low_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					found_q <= 1'b0;
					fr_q    <= '0;
					fc_q    <= '0;
					k_q     <= '0;
					cnt_q   <= '0;
					scan_q  <= 1'b0;
					base_q  <= '0;
					pr_q    <= pr_c;
					pc_q    <= pc_c;
					unique case (op_q)
						OP_PLACE, OP_PROBE: begin
							if (!size_ok) begin
								state_q <= S_LOWI;
							end else if (hint_q) begin
								state_q <= S_HCAND;
							end else begin
								scan_q  <= 1'b1;
								state_q <= S_SCAN;
							end
						end
						OP_REMOVE: begin
							if (size_ok) begin
								base_q  <= {2'b00, prow_q};
								wcol_q  <= {2'b00, pcol_q};
								n_q     <= rm_n;
								state_q <= S_WR;
							end else begin
								state_q <= S_LOWI;
							end
						end
						OP_CLEAR: state_q <= S_LOWI;
					endcase
				end
				S_HCAND: begin
					if (k_q == HINT_TRIES) begin
						scan_q  <= 1'b1;
						base_q  <= '0;
						state_q <= S_SCAN;
					end else if (cand_ok) begin
						base_q  <= cr[7:0];
						cand_q  <= cc[5:0];
						cnt_q   <= '0;
						or_q    <= '0;
						state_q <= S_ACC;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_SCAN: begin
					if (scan_fits) begin
						cnt_q   <= '0;
						or_q    <= '0;
						state_q <= S_ACC;
					end else begin
						state_q <= S_LOWI;
					end
				end
				S_ACC: begin
					if (rd_vld_q) begin
						or_q <= or_q | rdata;
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == h_q - 4'd1) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (scan_q ? fit.any : fit.hit) begin
						found_q <= 1'b1;
						fr_q    <= base_q;
						fc_q    <= scan_q ? fit.first : cand_q;
						if (op_q == OP_PLACE) begin
							wcol_q  <= scan_q ? fit.first : cand_q;
							n_q     <= h_q;
							cnt_q   <= '0;
							state_q <= S_WR;
						end else begin
							state_q <= S_LOWI;
						end
					end else if (scan_q) begin
						base_q  <= base_q + 8'd1;
						state_q <= S_SCAN;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_HCAND;
					end
				end
				S_WR: begin
					if (cnt_q < n_q) begin
						cnt_q <= cnt_q + 4'd1;
					end else if (!rd_vld_q) begin
						state_q <= S_LOWI;
					end
				end
				S_LOWI: begin
					lrow_q  <= row_t'(nr) - 8'd1;
					lmore_q <= (nr != 7'd0);
					low_q   <= '0;
					state_q <= S_LOW;
				end
				S_LOW: begin
					if (lhit) begin
						low_q   <= rd_row_q;
						state_q <= S_FIN;
					end else if (lmore_q) begin
						lrow_q  <= lrow_q - 8'd1;
						lmore_q <= (lrow_q != 8'd0);
					end else if (!rd_vld_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response register
	assign out_load = (state_q == S_FIN) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_q;
			out_row_q   <= fr_q[5:0];
			out_col_q   <= fc_q[3:0];
			out_low_q   <= low_q[5:0];
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.found             = out_found_q;
	assign rsp.placed_row        = out_row_q;
	assign rsp.placed_col        = out_col_q;
	assign rsp.lowest_filled_row = out_low_q;

	assign fit_end_ok = (({1'b0, fr_q} + {5'b00000, h_q}) <= {2'b00, nr})
		&& (({1'b0, fc_q} + {3'b000, w_q}) <= {2'b00, nc});

	`GRFF_CHK_IMPL(a_eval_has_data, state_q == S_EVAL, rd_vld_q, "band evaluated without row data")
	`GRFF_CHK_IMPL(a_rmw_no_clash, ram_we && rd_issue, ram_wa != ram_ra, "RMW write hits read row")
	`GRFF_CHK_IMPL(a_found_in_grid, out_load && found_q, fit_end_ok, "found rectangle leaves grid")
	`GRFF_CHK_NEXT(a_accept_prep, req.valid && req.ready, state_q == S_PREP, "accept did not start")

endmodule
